### src/gcs_pkg.sv
package gcs_pkg;

  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned NUM_DELAYS    = 8;
  localparam int unsigned DELAY_IDX_W   = $clog2(NUM_DELAYS);
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned HOR_BITS      = 8;

  localparam logic [TIME_BITS-1:0] DELAY_INIT_MS = TIME_BITS'(500);
  localparam logic [HOR_BITS-1:0]  HOR_FULL      = 8'd255;
  localparam logic [HOR_BITS-1:0]  HOR_NONE      = 8'd0;

  // host trigger codes
  localparam logic [1:0] TRIG_START = 2'd1;
  localparam logic [1:0] TRIG_END   = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATE_BACK = 4'd0,
    REG_GRAB        = 4'd1,
    REG_CLOSE       = 4'd2,
    REG_RETRACT     = 4'd3,
    REG_ROTATE      = 4'd4,
    REG_RELEASE     = 4'd5,
    REG_RESET       = 4'd6,
    REG_COMPLETE    = 4'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_STANDBY     = 4'd0,
    PH_TRACKING    = 4'd1,
    PH_ROTATE_BACK = 4'd2,
    PH_EXTEND      = 4'd3,
    PH_CLOSE       = 4'd4,
    PH_RETRACT     = 4'd5,
    PH_ROTATE      = 4'd6,
    PH_OPEN        = 4'd7,
    PH_NEUTRAL     = 4'd8,
    PH_COMPLETE    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    ST_STOPPED  = 3'd0,
    ST_STANDBY  = 3'd1,
    ST_TRACKING = 3'd2,
    ST_CUTTING  = 3'd3,
    ST_COMPLETE = 3'd4
  } status_t;

  // persistent sequencer state apart from the saved position
  typedef struct packed {
    logic [3:0]           phase;
    logic [TIME_BITS-1:0] phase_start_ms;
    status_t              last_status;
    logic                 open_level;
    logic                 close_level;
    logic                 rotate_level;
  } seq_state_t;

  // control part of one result
  typedef struct packed {
    status_t             status;
    logic                open_valve;
    logic                close_valve;
    logic                rotate_valve;
    logic                hor_write;
    logic [HOR_BITS-1:0] hor_value;
    logic                track_write;
    logic                vert_write;
    logic                base_capture;
    logic [3:0]          phase_now;
  } step_ctl_t;

endpackage

### src/gcs_step.sv
module gcs_step #(
  parameter int unsigned POSITION_BITS = gcs_pkg::POSITION_BITS
) (
  input  gcs_pkg::seq_state_t                  cur,
  input  logic signed [POSITION_BITS-1:0]      saved_position,
  input  logic [gcs_pkg::TIME_BITS-1:0]        delays [gcs_pkg::NUM_DELAYS],
  input  logic [gcs_pkg::TIME_BITS-1:0]        now_ms,
  input  logic [1:0]                           trigger,
  input  logic                                 auto_mode,
  input  logic signed [POSITION_BITS-1:0]      track_target,
  input  logic signed [POSITION_BITS-1:0]      vertical_position,
  output gcs_pkg::seq_state_t                  nxt,
  output logic signed [POSITION_BITS-1:0]      saved_position_next,
  output gcs_pkg::step_ctl_t                   ctl,
  output logic signed [POSITION_BITS-1:0]      track_value,
  output logic signed [POSITION_BITS-1:0]      vert_value
);

  logic [gcs_pkg::DELAY_IDX_W-1:0] delay_idx;
  logic [gcs_pkg::TIME_BITS-1:0]   elapsed;
  logic                            waited;

  // timed phases two through nine use delay registers zero through seven
  assign delay_idx = gcs_pkg::DELAY_IDX_W'(cur.phase - 4'd2);
  assign elapsed   = now_ms - cur.phase_start_ms;
  assign waited    = elapsed >= delays[delay_idx];

  always_comb begin
    nxt                 = cur;
    saved_position_next = saved_position;
    ctl                 = '0;
    track_value         = '0;
    vert_value          = '0;

    unique case (cur.phase)
      gcs_pkg::PH_STANDBY: begin
        nxt.open_level     = 1'b1;
        nxt.close_level    = 1'b0;
        nxt.rotate_level   = 1'b1;
        nxt.phase_start_ms = now_ms;
        if (trigger == gcs_pkg::TRIG_START && auto_mode) begin
          saved_position_next = vertical_position;
          ctl.base_capture    = 1'b1;
          nxt.phase           = gcs_pkg::PH_TRACKING;
        end
        nxt.last_status = gcs_pkg::ST_STANDBY;
      end
      gcs_pkg::PH_TRACKING: begin
        ctl.track_write = 1'b1;
        track_value     = track_target;
        if (!auto_mode) begin
          // manual mode aborts: restore vertical, retract horizontal
          ctl.vert_write = 1'b1;
          vert_value     = saved_position;
          ctl.hor_write  = 1'b1;
          ctl.hor_value  = gcs_pkg::HOR_NONE;
          nxt.phase      = gcs_pkg::PH_STANDBY;
        end else if (trigger == gcs_pkg::TRIG_END) begin
          nxt.phase          = gcs_pkg::PH_ROTATE_BACK;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_TRACKING;
      end
      gcs_pkg::PH_ROTATE_BACK: begin
        nxt.rotate_level = 1'b0;
        if (waited) begin
          nxt.phase          = gcs_pkg::PH_EXTEND;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_EXTEND: begin
        if (waited) begin
          nxt.open_level     = 1'b1;
          nxt.close_level    = 1'b0;
          ctl.hor_write      = 1'b1;
          ctl.hor_value      = gcs_pkg::HOR_FULL;
          nxt.phase          = gcs_pkg::PH_CLOSE;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_CLOSE: begin
        if (waited) begin
          nxt.open_level     = 1'b0;
          nxt.close_level    = 1'b1;
          nxt.phase          = gcs_pkg::PH_RETRACT;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_RETRACT: begin
        if (waited) begin
          ctl.hor_write      = 1'b1;
          ctl.hor_value      = gcs_pkg::HOR_NONE;
          ctl.vert_write     = 1'b1;
          nxt.phase          = gcs_pkg::PH_ROTATE;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_ROTATE: begin
        if (waited) begin
          nxt.rotate_level   = 1'b1;
          nxt.phase          = gcs_pkg::PH_OPEN;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_OPEN: begin
        if (waited) begin
          nxt.open_level     = 1'b1;
          nxt.close_level    = 1'b0;
          nxt.phase          = gcs_pkg::PH_NEUTRAL;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_NEUTRAL: begin
        nxt.open_level  = 1'b0;
        nxt.close_level = 1'b0;
        if (waited) begin
          nxt.phase          = gcs_pkg::PH_COMPLETE;
          nxt.phase_start_ms = now_ms;
        end
        nxt.last_status = gcs_pkg::ST_CUTTING;
      end
      gcs_pkg::PH_COMPLETE: begin
        if (waited) begin
          ctl.vert_write  = 1'b1;
          vert_value      = saved_position;
          nxt.phase       = gcs_pkg::PH_STANDBY;
          nxt.last_status = gcs_pkg::ST_COMPLETE;
        end
      end
      default: begin
        nxt.last_status = gcs_pkg::ST_STOPPED;
      end
    endcase

    ctl.status       = nxt.last_status;
    ctl.open_valve   = nxt.open_level;
    ctl.close_valve  = nxt.close_level;
    ctl.rotate_valve = nxt.rotate_level;
    ctl.phase_now    = nxt.phase;
  end

endmodule

### src/timed_gripper_cut_sequencer.sv
// timed gripper cut sequencer
// poll channel (in_valid/in_ready): one request per poll with the current
//   millisecond time, trigger, mode, tracking target and vertical position
// result channel (out_valid/out_ready): exactly one result per request with
//   status, valve levels, cylinder commands and the phase after the poll
// config channel (cfg_valid/cfg_ready): cfg_index 0..7 selects one of the
//   eight delay registers, cfg_data is the delay in ms; other indexes are
//   dropped; cfg_ready is always high, write only while no poll is in flight
// stages: an accepted request is held in the poll register, and its result
//   in the result register; two register stages (poll, result register)
// throughput: one request per cycle while out_ready is high; the step is a
//   phase decode, one 32-bit subtract, delay compare and register updates
// a stalled receiver holds the result register; the poll register still
//   takes one more request, then in_ready drops until out_ready returns
// reset: phase standby, all delays 500 ms, levels and status zero,
//   both pipeline stages empty
module timed_gripper_cut_sequencer #(
  parameter int unsigned POSITION_BITS = gcs_pkg::POSITION_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // poll channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [gcs_pkg::TIME_BITS-1:0]          now_ms,
  input  logic [1:0]                             trigger,
  input  logic                                   auto_mode,
  input  logic signed [POSITION_BITS-1:0]        track_target,
  input  logic signed [POSITION_BITS-1:0]        vertical_position,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [2:0]                             status,
  output logic                                   open_valve,
  output logic                                   close_valve,
  output logic                                   rotate_valve,
  output logic                                   hor_write,
  output logic [gcs_pkg::HOR_BITS-1:0]           hor_value,
  output logic                                   track_write,
  output logic signed [POSITION_BITS-1:0]        track_value,
  output logic                                   vert_write,
  output logic signed [POSITION_BITS-1:0]        vert_value,
  output logic                                   base_capture,
  output logic [3:0]                             phase_now,
  // config channel
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [gcs_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [gcs_pkg::TIME_BITS-1:0]          cfg_data
);

  // delay registers
  logic [gcs_pkg::TIME_BITS-1:0] delays [gcs_pkg::NUM_DELAYS];

  // poll register stage
  logic                               s1_valid;
  logic [gcs_pkg::TIME_BITS-1:0]      s1_now_ms;
  logic [1:0]                         s1_trigger;
  logic                               s1_auto_mode;
  logic signed [POSITION_BITS-1:0]    s1_track_target;
  logic signed [POSITION_BITS-1:0]    s1_vertical_position;

  // sequencer state
  gcs_pkg::seq_state_t                seq_state;
  gcs_pkg::seq_state_t                seq_state_next;
  logic signed [POSITION_BITS-1:0]    saved_position;
  logic signed [POSITION_BITS-1:0]    saved_position_next;

  // step results
  gcs_pkg::step_ctl_t                 step_ctl;
  logic signed [POSITION_BITS-1:0]    step_track_value;
  logic signed [POSITION_BITS-1:0]    step_vert_value;

  // result register
  gcs_pkg::step_ctl_t                 res_ctl;

  logic out_load;
  logic step_fire;

  // result register loads when empty or being drained
  assign out_load  = !out_valid || out_ready;
  assign step_fire = s1_valid && out_load;
  assign in_ready  = !s1_valid || out_load;
  assign cfg_ready = 1'b1;

  // config writes, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < gcs_pkg::NUM_DELAYS; i++) begin
        delays[i] <= gcs_pkg::DELAY_INIT_MS;
      end
    end else if (cfg_valid && cfg_ready &&
                 cfg_index <= gcs_pkg::CFG_IDX_W'(gcs_pkg::REG_COMPLETE)) begin
      delays[gcs_pkg::DELAY_IDX_W'(cfg_index)] <= cfg_data;
    end
  end

  // poll register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_now_ms            <= now_ms;
      s1_trigger           <= trigger;
      s1_auto_mode         <= auto_mode;
      s1_track_target      <= track_target;
      s1_vertical_position <= vertical_position;
    end
  end

  gcs_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .cur                 (seq_state),
    .saved_position      (saved_position),
    .delays              (delays),
    .now_ms              (s1_now_ms),
    .trigger             (s1_trigger),
    .auto_mode           (s1_auto_mode),
    .track_target        (s1_track_target),
    .vertical_position   (s1_vertical_position),
    .nxt                 (seq_state_next),
    .saved_position_next (saved_position_next),
    .ctl                 (step_ctl),
    .track_value         (step_track_value),
    .vert_value          (step_vert_value)
  );

  // sequencer state advances once per poll, in poll order
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state.phase          <= gcs_pkg::PH_STANDBY;
      seq_state.phase_start_ms <= '0;
      seq_state.last_status    <= gcs_pkg::ST_STOPPED;
      seq_state.open_level     <= 1'b0;
      seq_state.close_level    <= 1'b0;
      seq_state.rotate_level   <= 1'b0;
      saved_position           <= '0;
    end else if (step_fire) begin
      seq_state      <= seq_state_next;
      saved_position <= saved_position_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      res_ctl     <= step_ctl;
      track_value <= step_track_value;
      vert_value  <= step_vert_value;
    end
  end

  assign status       = res_ctl.status;
  assign open_valve   = res_ctl.open_valve;
  assign close_valve  = res_ctl.close_valve;
  assign rotate_valve = res_ctl.rotate_valve;
  assign hor_write    = res_ctl.hor_write;
  assign hor_value    = res_ctl.hor_value;
  assign track_write  = res_ctl.track_write;
  assign vert_write   = res_ctl.vert_write;
  assign base_capture = res_ctl.base_capture;
  assign phase_now    = res_ctl.phase_now;

  // base capture only on the start of tracking
  a_capture_starts_tracking: assert property (@(posedge clk) disable iff (rst)
    out_valid && base_capture |-> phase_now == gcs_pkg::PH_TRACKING)
    else $error("base capture without entering tracking");

  // full extension only on leaving the extend wait
  a_full_ext_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid && hor_write && hor_value == gcs_pkg::HOR_FULL
      |-> phase_now == gcs_pkg::PH_CLOSE)
    else $error("full extension outside the extend step");

  // complete status only when returning to standby
  a_complete_standby: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == gcs_pkg::ST_COMPLETE
      |-> phase_now == gcs_pkg::PH_STANDBY && vert_write)
    else $error("complete reported without restoring position");

  // gripper never driven open and closed together
  a_valves_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(open_valve && close_valve))
    else $error("open and close valves both high");

  // phase never leaves the defined range
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    seq_state.phase <= gcs_pkg::PH_COMPLETE)
    else $error("phase out of range");

  // a stalled full pipeline refuses polls
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("poll taken while both stages are held");

endmodule
